// ----- design/wmb_pkg.sv -----
// shared types, sizes, register indexes and reset values of the window mean binarizer
// no dependencies; imported by every module of the block
package wmb_pkg;

    localparam int WINDOW_LEN   = 32;
    localparam int NUM_CHANNELS = 4;
    localparam int CH_MAX       = 4;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int SUM_W    = 21;
    localparam int PROD_W   = SUM_W + COEF_W;
    localparam int BITS_W   = 32;
    localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
    localparam int IDX_W    = 3;

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [COEF_W-1:0]   t_coef;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [PROD_W-1:0]   t_prod;
    typedef logic [BITS_W-1:0]   t_bits;
    typedef logic [FILL_W-1:0]   t_fill;

    typedef enum logic [IDX_W-1:0] {
        REG_COEF_CH0 = 3'd0,
        REG_COEF_CH1 = 3'd1,
        REG_COEF_CH2 = 3'd2,
        REG_COEF_CH3 = 3'd3,
        REG_MARK_A   = 3'd4,
        REG_MARK_B   = 3'd5,
        REG_MARK_C   = 3'd6
    } t_reg_idx;

    localparam t_coef   COEF_CH0_RST = 16'd63766;
    localparam t_coef   COEF_CH1_RST = 16'd60948;
    localparam t_coef   COEF_CH2_RST = 16'd59310;
    localparam t_coef   COEF_CH3_RST = 16'd58982;
    localparam t_sample MARK_A_RST   = 16'd65535;
    localparam t_sample MARK_B_RST   = 16'd15000;
    localparam t_sample MARK_C_RST   = 16'd39064;

    // per-request control handed from the top level to each channel accumulator
    typedef struct packed {
        logic shift;  // a request is taken this cycle
        logic full;   // window already held WINDOW_LEN samples before it
    } t_step_ctl;

endpackage

// ----- design/wmb_cell.sv -----
// one window position of one channel: holds a sample, passes it on, compares it
// depends on wmb_pkg
module wmb_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  wmb_pkg::t_sample i_din,
    input  wmb_pkg::t_sum    i_limit,
    output wmb_pkg::t_sample o_dout,
    output logic            o_bit
);
    import wmb_pkg::*;

    t_sample r_sample;
    t_sample n_sample;
    t_sum    w_scaled;

    always_comb begin
        n_sample = i_shift ? i_din : r_sample;
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
    end

    // s > floor(p / (W * 2^16))  is the same as  s * W > floor(p / 2^16)
    assign w_scaled = SUM_W'(r_sample) * SUM_W'(WINDOW_LEN);
    assign o_bit    = (w_scaled > i_limit);
    assign o_dout   = r_sample;

endmodule

// ----- design/wmb_chan.sv -----
// running window sum and scaled limit of one channel
// depends on wmb_pkg
module wmb_chan (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wmb_pkg::t_step_ctl i_ctl,
    input  wmb_pkg::t_sample   i_sample,
    input  wmb_pkg::t_sample   i_oldest,
    input  wmb_pkg::t_coef     i_coef,
    output wmb_pkg::t_sum      o_limit
);
    import wmb_pkg::*;

    t_sum  r_sum;
    t_sum  n_sum;
    t_sum  w_drop;
    t_prod w_prod;

    always_comb begin
        w_drop = i_ctl.full ? SUM_W'(i_oldest) : '0;
        n_sum  = r_sum;
        if (i_ctl.shift) begin
            n_sum = r_sum - w_drop + SUM_W'(i_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    // sum * coef, top bits compared against sample * window length in the cells
    assign w_prod  = PROD_W'(r_sum) * PROD_W'(i_coef);
    assign o_limit = w_prod[PROD_W-1:COEF_W];

endmodule

// ----- design/window_mean_binarizer_top.sv -----
// top level of the window mean binarizer: config registers, fill control, output register
// depends on wmb_pkg, wmb_chan and wmb_cell
//
// One request per clock is taken while o_in_stall is low: each request carries one
// 16-bit sample per channel, which shifts into a row of 32 cells per channel while
// the oldest one drops out of the running sum. Once 32 requests have arrived, each
// request gives one result: the request is registered into the cells and the running
// sums, then the compare stage multiplies each sum by the channel's Q0.16
// coefficient and every cell compares its own sample against that threshold, and the
// 32 bits per channel (oldest sample in the MSB) plus the empty flag land in the output
// register once it can take them. The first 31 requests after reset give no result.
// The multiplier followed by the cell comparators is the one stage that sets the clock.
// While a result waits in the output register and the downstream side stalls, one
// more request can be taken and completes into the comparator stage; after that the
// input stall rises until the output register is read. Coefficients and marker
// values are written through the plain write port; a write to index 7 is ignored.
module window_mean_binarizer_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write port
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  wmb_pkg::t_sample  i_cfg_data,
    // sample requests
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  wmb_pkg::t_sample  i_sample_ch0,
    input  wmb_pkg::t_sample  i_sample_ch1,
    input  wmb_pkg::t_sample  i_sample_ch2,
    input  wmb_pkg::t_sample  i_sample_ch3,
    // result requests
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output wmb_pkg::t_bits    o_bits_ch0,
    output wmb_pkg::t_bits    o_bits_ch1,
    output wmb_pkg::t_bits    o_bits_ch2,
    output wmb_pkg::t_bits    o_bits_ch3,
    output logic              o_empty_flag
);
    import wmb_pkg::*;

    localparam t_fill FILL_FULL = FILL_W'(WINDOW_LEN);
    localparam t_fill FILL_LAST = FILL_W'(WINDOW_LEN - 1);

    // configuration registers
    t_coef   r_coef [CH_MAX];
    t_sample r_mark_a;
    t_sample r_mark_b;
    t_sample r_mark_c;

    // fill and pipeline control
    t_fill   r_fill;
    t_fill   n_fill;
    logic    r_b_valid;    // compare stage holds a complete window
    logic    n_b_valid;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    w_in_acc;
    logic    w_b_move;
    logic    w_full;
    t_step_ctl w_ctl;

    // output register
    t_bits   r_bits [CH_MAX];
    logic    r_empty;

    // datapath
    t_sample w_in   [CH_MAX];
    t_sample w_tap  [CH_MAX][WINDOW_LEN];
    t_sum    w_limit [CH_MAX];
    logic [WINDOW_LEN-1:0] w_cmp [CH_MAX];
    t_bits   w_bits [CH_MAX];
    t_sample w_old0;
    logic    w_empty;

    assign w_in[0] = i_sample_ch0;
    assign w_in[1] = i_sample_ch1;
    assign w_in[2] = i_sample_ch2;
    assign w_in[3] = i_sample_ch3;

    // handshake: the compare stage empties whenever the output register can take it
    assign w_b_move   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_b_valid && !w_b_move;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_full     = (r_fill == FILL_FULL);

    assign w_ctl.shift = w_in_acc;
    assign w_ctl.full  = w_full;

    // config writes, taken at any clock
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= COEF_CH0_RST;
            r_coef[1] <= COEF_CH1_RST;
            r_coef[2] <= COEF_CH2_RST;
            r_coef[3] <= COEF_CH3_RST;
            r_mark_a  <= MARK_A_RST;
            r_mark_b  <= MARK_B_RST;
            r_mark_c  <= MARK_C_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COEF_CH0: r_coef[0] <= i_cfg_data;
                REG_COEF_CH1: r_coef[1] <= i_cfg_data;
                REG_COEF_CH2: r_coef[2] <= i_cfg_data;
                REG_COEF_CH3: r_coef[3] <= i_cfg_data;
                REG_MARK_A:   r_mark_a  <= i_cfg_data;
                REG_MARK_B:   r_mark_b  <= i_cfg_data;
                REG_MARK_C:   r_mark_c  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // per channel: accumulator plus a row of cells, newest sample in cell 0
    for (genvar c = 0; c < CH_MAX; c++) begin : g_ch
        if (c < NUM_CHANNELS) begin : g_used
            wmb_chan u_chan (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_sample (w_in[c]),
                .i_oldest (w_tap[c][WINDOW_LEN-1]),
                .i_coef   (r_coef[c]),
                .o_limit  (w_limit[c])
            );
            for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
                t_sample w_din;
                if (k == 0) begin : g_head
                    assign w_din = w_in[c];
                end else begin : g_link
                    assign w_din = w_tap[c][k-1];
                end
                wmb_cell u_cell (
                    .i_clk   (i_clk),
                    .i_shift (w_in_acc),
                    .i_din   (w_din),
                    .i_limit (w_limit[c]),
                    .o_dout  (w_tap[c][k]),
                    .o_bit   (w_cmp[c][k])
                );
            end
            // oldest sample sits in the last cell, so it lands in bit WINDOW_LEN-1
            assign w_bits[c] = BITS_W'(w_cmp[c]);
        end else begin : g_unused
            for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_tie
                assign w_tap[c][k] = '0;
            end
            assign w_limit[c] = '0;
            assign w_cmp[c]   = '0;
            assign w_bits[c]  = '0;
        end
    end

    assign w_old0  = w_tap[0][WINDOW_LEN-1];
    assign w_empty = (w_old0 == r_mark_a) || (w_old0 == r_mark_b) || (w_old0 == r_mark_c);

    always_comb begin
        n_fill      = r_fill;
        n_b_valid   = r_b_valid;
        n_out_valid = r_out_valid;
        if (w_in_acc && !w_full) begin
            n_fill = r_fill + FILL_W'(1);
        end
        if (w_in_acc) begin
            n_b_valid = (r_fill >= FILL_LAST);
        end else if (w_b_move) begin
            n_b_valid = 1'b0;
        end
        if (r_b_valid && w_b_move) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_b_valid   <= n_b_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid && w_b_move) begin
            for (int c = 0; c < CH_MAX; c++) begin
                r_bits[c] <= w_bits[c];
            end
            r_empty <= w_empty;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_bits_ch0   = r_bits[0];
    assign o_bits_ch1   = r_bits[1];
    assign o_bits_ch2   = r_bits[2];
    assign o_bits_ch3   = r_bits[3];
    assign o_empty_flag = r_empty;

    // a window reaches the compare stage only once the row is filled
    a_b_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> w_full)
        else $error("compare stage valid before window filled");

    // the request that completes the window must produce a result
    a_fill_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (r_fill >= FILL_LAST)) |=> r_b_valid)
        else $error("filled window did not reach compare stage");

    // a blocked compare stage keeps its window and its row of cells
    a_b_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !w_b_move) |=> (r_b_valid && $stable(w_old0)))
        else $error("compare stage lost its window while blocked");

    // fill count saturates at the window length
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond window length");

endmodule

// ----- verif/window_mean_binarizer_top_test.sv -----
// self-checking bench for window_mean_binarizer_top: drives sample requests and register writes
// depends on wmb_pkg and the design files of the window mean binarizer
module window_mean_binarizer_top_test;
    import wmb_pkg::*;

    // clock, reset and every port of the block
    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    i_cfg_we;
    logic [2:0] i_cfg_idx;
    t_sample i_cfg_data;
    logic    i_in_valid;
    logic    o_in_stall;
    t_sample i_sample_ch0;
    t_sample i_sample_ch1;
    t_sample i_sample_ch2;
    t_sample i_sample_ch3;
    logic    o_out_valid;
    logic    i_out_stall;
    t_bits   o_bits_ch0;
    t_bits   o_bits_ch1;
    t_bits   o_bits_ch2;
    t_bits   o_bits_ch3;
    logic    o_empty_flag;

    // one request: a sample per channel, and one result: the window bits plus the empty flag
    typedef logic [CH_MAX-1:0][SAMPLE_W-1:0] t_sample_set;
    typedef logic [CH_MAX-1:0][COEF_W-1:0]   t_coef_set;
    typedef logic [2:0][SAMPLE_W-1:0]        t_mark_set;
    typedef struct packed {
        logic [CH_MAX-1:0][BITS_W-1:0] bits;
        logic                          empty;
    } t_window_result;

    localparam logic [2:0]  REG_IDX_UNUSED = 3'd7;
    localparam t_reg_idx    COEF_REG [CH_MAX] = '{REG_COEF_CH0, REG_COEF_CH1,
                                                   REG_COEF_CH2, REG_COEF_CH3};
    localparam int unsigned SETTLE_CYCLES  = 8;
    localparam int unsigned HOLD_CYCLES    = 150;   // long downstream hold-off
    localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no request moving on either side
    localparam int unsigned NO_EVENT       = 32'hFFFF_FFFF;

    // window history, running sums and registers kept alongside the block
    class binarizer_scoreboard;
        t_sample        hist [CH_MAX][WINDOW_LEN];
        t_sum           sums [CH_MAX];
        t_coef          coef [CH_MAX];
        t_sample        marks [3];
        int unsigned    fill;
        int unsigned    wr_pos;
        t_window_result windows_due [$];
        int unsigned    mismatches;
        int unsigned    requests_seen;
        int unsigned    results_seen;

        function new();
            coef[0]  = COEF_CH0_RST;
            coef[1]  = COEF_CH1_RST;
            coef[2]  = COEF_CH2_RST;
            coef[3]  = COEF_CH3_RST;
            marks[0] = MARK_A_RST;
            marks[1] = MARK_B_RST;
            marks[2] = MARK_C_RST;
            for (int c = 0; c < CH_MAX; c++) sums[c] = '0;
            fill          = 0;
            wr_pos        = 0;
            mismatches    = 0;
            requests_seen = 0;
            results_seen  = 0;
        endfunction

        function void write_reg(logic [2:0] idx, t_sample data);
            case (idx)
                REG_COEF_CH0: coef[0]  = data;
                REG_COEF_CH1: coef[1]  = data;
                REG_COEF_CH2: coef[2]  = data;
                REG_COEF_CH3: coef[3]  = data;
                REG_MARK_A:   marks[0] = data;
                REG_MARK_B:   marks[1] = data;
                REG_MARK_C:   marks[2] = data;
                default: ;
            endcase
        endfunction

        // shift the request into every window and queue the window it completes
        function void note_request(t_sample_set s);
            t_window_result want;
            logic [63:0]    prod;
            logic [63:0]    thr;
            t_sample        old;
            t_bits          bits;
            bit             full;
            full = (fill >= WINDOW_LEN);
            requests_seen++;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                if (full) sums[c] = sums[c] - hist[c][wr_pos];
                hist[c][wr_pos] = s[c];
                sums[c] = sums[c] + s[c];
            end
            wr_pos = (wr_pos + 1) % WINDOW_LEN;
            if (fill < WINDOW_LEN) fill++;
            if (fill < WINDOW_LEN) return;
            for (int c = 0; c < CH_MAX; c++) begin
                bits = '0;
                if (c < NUM_CHANNELS) begin
                    prod = 64'(sums[c]) * 64'(coef[c]);
                    thr  = prod / (64'(WINDOW_LEN) << 16);
                    for (int k = 0; k < WINDOW_LEN; k++) begin
                        old  = hist[c][(wr_pos + k) % WINDOW_LEN];
                        bits = (bits << 1) | t_bits'(64'(old) > thr);
                    end
                end
                want.bits[c] = bits;
            end
            old = hist[0][wr_pos];
            want.empty = (old == marks[0]) || (old == marks[1]) || (old == marks[2]);
            windows_due.push_back(want);
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH at result %0d: %s", results_seen, what);
        endtask

        task check_result(t_window_result got);
            t_window_result want;
            results_seen++;
            if (windows_due.size() == 0) begin
                report("result with no window pending");
                return;
            end
            want = windows_due.pop_front();
            for (int c = 0; c < CH_MAX; c++)
                if (got.bits[c] !== want.bits[c])
                    report($sformatf("bits_ch%0d got %h want %h", c, got.bits[c],
                                     want.bits[c]));
            if (got.empty !== want.empty)
                report($sformatf("empty_flag got %b want %b", got.empty, want.empty));
        endtask
    endclass

    binarizer_scoreboard board = new();

    // idling knobs of the sender and receiver, the setting count and the drifting levels
    int unsigned sender_gap_pct     = 0;
    int unsigned receiver_stall_pct = 0;
    bit          hold_pending       = 1'b0;
    int unsigned settings_used      = 0;
    t_sample     level [CH_MAX];

    window_mean_binarizer_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample_ch0 (i_sample_ch0),
        .i_sample_ch1 (i_sample_ch1),
        .i_sample_ch2 (i_sample_ch2),
        .i_sample_ch3 (i_sample_ch3),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_bits_ch0   (o_bits_ch0),
        .o_bits_ch1   (o_bits_ch1),
        .o_bits_ch2   (o_bits_ch2),
        .o_bits_ch3   (o_bits_ch3),
        .o_empty_flag (o_empty_flag)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // downstream side: random stall, or a long hold-off when one is asked for
    initial begin : result_receiver
        int unsigned held;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                // block fills up behind the held output register meanwhile
                for (held = 0; held < HOLD_CYCLES; held++) @(negedge i_clk);
            end
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // every accepted result goes to the scoreboard, sampled at the rising edge
    always @(posedge i_clk) begin
        t_window_result seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.bits[0] = o_bits_ch0;
            seen.bits[1] = o_bits_ch1;
            seen.bits[2] = o_bits_ch2;
            seen.bits[3] = o_bits_ch3;
            seen.empty   = o_empty_flag;
            board.check_result(seen);
        end
    end

    // give up when nothing moves on either side for too long
    always @(posedge i_clk) begin : watchdog
        int unsigned quiet;
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
        else quiet++;
        if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", quiet);
            $display("Mismatches found");
            $finish;
        end
    end

    // register write, one per clock; caller lowers the write enable afterwards
    task automatic put_reg(logic [2:0] idx, t_sample data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        board.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // full register setting, plus one write to the unused index that must be ignored
    task automatic load_setting(t_coef_set coefs, t_mark_set marks);
        for (int c = 0; c < CH_MAX; c++) put_reg(COEF_REG[c], coefs[c]);
        put_reg(REG_MARK_A, marks[0]);
        put_reg(REG_MARK_B, marks[1]);
        put_reg(REG_MARK_C, marks[2]);
        put_reg(REG_IDX_UNUSED, t_sample'($urandom));
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    // offer one request, with a random gap first; returns at the falling edge after acceptance
    task automatic offer_request(t_sample_set s);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_sample_ch0 <= s[0];
        i_sample_ch1 <= s[1];
        i_sample_ch2 <= s[2];
        i_sample_ch3 <= s[3];
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(s);
        @(negedge i_clk);
    endtask

    // stop offering until every pending window has come out, then let the pipe settle
    task automatic wait_drained(int unsigned settle);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (board.windows_due.size() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // extremes, marker values, a drifting level near the threshold, or plain noise
    function automatic t_sample pick_sample(int c);
        int unsigned roll;
        roll = $urandom_range(99);
        if ($urandom_range(15) == 0) level[c] = t_sample'($urandom);
        if (roll < 6)  return '0;
        if (roll < 12) return '1;
        if (roll < 20) return board.marks[$urandom_range(2)];
        if (roll < 50) return t_sample'($urandom);
        return level[c] + t_sample'($urandom_range(64)) - t_sample'(32);
    endfunction

    function automatic t_sample_set random_set();
        t_sample_set s;
        for (int c = 0; c < CH_MAX; c++) s[c] = pick_sample(c);
        return s;
    endfunction

    // directed requests: all-zero, all-ones, checkerboards, single bits, 7FFF, marker hits
    function automatic t_sample_set directed_set(int unsigned k);
        t_sample_set s;
        for (int c = 0; c < CH_MAX; c++) begin
            case (k % 8)
                0: s[c] = 16'h0000;
                1: s[c] = 16'hFFFF;
                2: s[c] = (c % 2) ? 16'hAAAA : 16'h5555;
                3: s[c] = (c % 2) ? 16'h5555 : 16'hAAAA;
                4: s[c] = 16'h0001 << ((k + c) % 16);
                5: s[c] = 16'h8000;
                6: s[c] = 16'h7FFF;
                default: s[c] = 16'h0001;
            endcase
        end
        // channel 0 cycles through the three marker values every third request
        if (k % 3 == 0) s[0] = board.marks[(k / 3) % 3];
        return s;
    endfunction

    task automatic run_phase(int unsigned count, int unsigned gap_pct, int unsigned stall_pct,
                             int unsigned hold_at, int unsigned pause_at);
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        for (int unsigned n = 0; n < count; n++) begin
            if (n == hold_at)  hold_pending = 1'b1;
            if (n == pause_at) wait_drained(0);
            offer_request(random_set());
        end
    endtask

    function automatic t_coef_set random_coefs();
        t_coef_set v;
        for (int c = 0; c < CH_MAX; c++) v[c] = t_coef'($urandom);
        return v;
    endfunction

    initial begin : stimulus
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_sample_ch0 = '0;
        i_sample_ch1 = '0;
        i_sample_ch2 = '0;
        i_sample_ch3 = '0;
        for (int c = 0; c < CH_MAX; c++) level[c] = t_sample'($urandom);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part: coefficient extremes and marker extremes, sender mostly busy;
        // the window is still filling when it ends, so no result is expected yet
        sender_gap_pct     = 15;
        receiver_stall_pct = 61;
        load_setting({16'd1, 16'd32768, 16'd65535, 16'd0},
                     {16'd12345, 16'd65535, 16'd0});
        for (int unsigned k = 0; k < 24; k++) offer_request(directed_set(k));
        wait_drained(SETTLE_CYCLES);

        // reset values back in; sender mostly busy, receiver stalls a lot,
        // with one long downstream hold-off in the middle
        load_setting({COEF_CH3_RST, COEF_CH2_RST, COEF_CH1_RST, COEF_CH0_RST},
                     {MARK_C_RST, MARK_B_RST, MARK_A_RST});
        run_phase(206, 15, 61, 100, NO_EVENT);
        wait_drained(SETTLE_CYCLES);

        // random setting; roles swapped, and the sender pauses until all is out
        load_setting(random_coefs(),
                     {t_sample'($urandom), t_sample'($urandom), t_sample'($urandom)});
        run_phase(206, 61, 15, NO_EVENT, 110);
        wait_drained(SETTLE_CYCLES);

        // full-scale coefficients, markers at both ends; back to back
        load_setting({16'd65535, 16'd65535, 16'd65535, 16'd65535},
                     {t_sample'($urandom), 16'd0, 16'd65535});
        run_phase(206, 0, 0, NO_EVENT, NO_EVENT);
        wait_drained(SETTLE_CYCLES);

        // zero and full-scale coefficients mixed with random ones
        load_setting({t_coef'($urandom), t_coef'($urandom), 16'd65535, 16'd0},
                     {t_sample'($urandom), t_sample'($urandom), t_sample'($urandom)});
        run_phase(206, 0, 0, NO_EVENT, NO_EVENT);
        wait_drained(SETTLE_CYCLES);

        $display("run covered %0d sample requests and %0d window results", board.requests_seen,
                 board.results_seen);
        $display("across %0d register settings with varied idling and stalls", settings_used);
        if (board.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ----- window_mean_binarizer_top.f -----
design/wmb_pkg.sv
design/wmb_cell.sv
design/wmb_chan.sv
design/window_mean_binarizer_top.sv
verif/window_mean_binarizer_top_test.sv
